// ===== src/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the one-wire bus master
// Phase encoding, command codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int FUNC_W  = 3;
  localparam int DATA_W  = 8;
  localparam int LINES   = 3;
  localparam int SEL_W   = 2;
  localparam int CNT_W   = 10;
  localparam int LIM_W   = 8;
  localparam int BIDX_W  = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 10;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_HIGH  = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_HIGH   = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_TAIL   = 4'd8
  } phase_t;

  typedef enum logic [FUNC_W-1:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WBYTE = 3'd2,
    OP_RBYTE = 3'd3,
    OP_WBIT  = 3'd4,
    OP_RBIT  = 3'd5
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BUS_SELECT    = 3'd0,
    CFG_RESET_LOW     = 3'd1,
    CFG_PRES_WAIT     = 3'd2,
    CFG_PRES_LOW      = 3'd3,
    CFG_WR_ONE_LOW    = 3'd4,
    CFG_WR_ZERO_LOW   = 3'd5,
    CFG_RD_LOW        = 3'd6
  } cfg_idx_t;

  localparam logic [SEL_W-1:0] BUS_SELECT_RST     = 2'd0;
  localparam logic [CNT_W-1:0] RESET_LOW_RST      = 10'd750;
  localparam logic [LIM_W-1:0] PRES_WAIT_RST      = 8'd100;
  localparam logic [LIM_W-1:0] PRES_LOW_RST       = 8'd240;
  localparam logic [LIM_W-1:0] WR_ONE_LOW_RST     = 8'd8;
  localparam logic [LIM_W-1:0] WR_ZERO_LOW_RST    = 8'd70;
  localparam logic [LIM_W-1:0] RD_LOW_RST         = 8'd10;

endpackage

// ===== src/owm_in_if.sv =====
// ----------------------------------------------------------------------------
// owm_in_if: tick channel into the one-wire bus master
// Valid/ready handshake with command, data byte and sampled line level.
// ----------------------------------------------------------------------------
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data_value;
  logic       line_level;

  modport source (output valid, func, data_value, line_level, input ready);
  modport sink   (input valid, func, data_value, line_level, output ready);
endinterface

// ===== src/owm_out_if.sv =====
// ----------------------------------------------------------------------------
// owm_out_if: result channel of the one-wire bus master
// Valid/ready handshake with line drive masks, status and read value.
// ----------------------------------------------------------------------------
interface owm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] drive_low_mask;
  logic [2:0] drive_high_mask;
  logic       busy_res;
  logic       done_res;
  logic       presence_error;
  logic [7:0] read_value;

  modport source (output valid, drive_low_mask, drive_high_mask, busy_res, done_res,
                  presence_error, read_value, input ready);
  modport sink   (input valid, drive_low_mask, drive_high_mask, busy_res, done_res,
                  presence_error, read_value, output ready);
endinterface

// ===== src/one_wire_master.sv =====
// The result of a tick item sits in the result register in the cycle after it
// is accepted. Throughput: one item per cycle; the result register is the only
// stage, so a new item is taken whenever the result is empty or being taken.
// Reset (synchronous, active low) returns the bus phase to idle, clears the
// operation state and the result valid, and loads the timing registers' defaults.
// ----------------------------------------------------------------------------
// one_wire_master: tick-timed one-wire bus master
// Reset/presence, byte and bit write/read slots on one of three lines, or on none.
// ----------------------------------------------------------------------------
module one_wire_master #(
  parameter int RESET_RECOVER_TICKS   = 15,
  parameter int WRITE_ONE_HIGH_TICKS  = 58,
  parameter int WRITE_ZERO_HIGH_TICKS = 2,
  parameter int READ_TAIL_TICKS       = 45
) (
  input  logic                          clk,
  input  logic                          rst_n,
  owm_in_if.sink                        in_ch,
  owm_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [owm_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [owm_pkg::CDATA_W-1:0]   cfg_wdata
);
  import owm_pkg::*;

  localparam int CW = CNT_W + 1;
  localparam logic [CW-1:0] RECOVER_LIM = CW'(RESET_RECOVER_TICKS);
  localparam logic [CW-1:0] WR1_HI_LIM  = CW'(WRITE_ONE_HIGH_TICKS);
  localparam logic [CW-1:0] WR0_HI_LIM  = CW'(WRITE_ZERO_HIGH_TICKS);
  localparam logic [CW-1:0] TAIL_LIM    = CW'(READ_TAIL_TICKS);

  // Configuration registers
  logic [SEL_W-1:0] bus_select_r;
  logic [CNT_W-1:0] reset_low_r;
  logic [LIM_W-1:0] pres_wait_r, pres_low_r, wr_one_low_r, wr_zero_low_r, rd_low_r;

  // Bus state
  phase_t             phase_r, phase_nxt, phase_eff;
  logic [FUNC_W-1:0]  op_r, op_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BIDX_W-1:0]  bidx_r, bidx_nxt;
  logic [DATA_W-1:0]  sb_r, sb_nxt;

  // Result register
  logic               out_valid_r;
  logic [LINES-1:0]   lo_mask_r, hi_mask_r;
  logic               busy_r, done_r, err_r;
  logic [DATA_W-1:0]  rv_r;

  logic               accept, start;
  logic               lo, hi, done, err;
  logic [DATA_W-1:0]  rv;
  logic [LINES-1:0]   sel;
  logic [CW-1:0]      cnt_e, cnt_inc, lim;
  logic [FUNC_W-1:0]  op_e;
  logic [DATA_W-1:0]  sb_e;
  logic               func_ok;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_select_r  <= BUS_SELECT_RST;
      reset_low_r   <= RESET_LOW_RST;
      pres_wait_r   <= PRES_WAIT_RST;
      pres_low_r    <= PRES_LOW_RST;
      wr_one_low_r  <= WR_ONE_LOW_RST;
      wr_zero_low_r <= WR_ZERO_LOW_RST;
      rd_low_r      <= RD_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BUS_SELECT:  bus_select_r  <= cfg_wdata[SEL_W-1:0];
        CFG_RESET_LOW:   reset_low_r   <= cfg_wdata[CNT_W-1:0];
        CFG_PRES_WAIT:   pres_wait_r   <= cfg_wdata[LIM_W-1:0];
        CFG_PRES_LOW:    pres_low_r    <= cfg_wdata[LIM_W-1:0];
        CFG_WR_ONE_LOW:  wr_one_low_r  <= cfg_wdata[LIM_W-1:0];
        CFG_WR_ZERO_LOW: wr_zero_low_r <= cfg_wdata[LIM_W-1:0];
        CFG_RD_LOW:      rd_low_r      <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A command only starts from idle; the command tick is the first tick of its work.
  assign func_ok = in_ch.func inside {OP_RESET, OP_WBYTE, OP_RBYTE, OP_WBIT, OP_RBIT};
  assign start   = (phase_r == PH_IDLE) && func_ok;

  always_comb begin
    phase_eff = phase_r;
    op_e      = op_r;
    cnt_e     = {1'b0, cnt_r};
    sb_e      = sb_r;
    if (start) begin
      op_e  = in_ch.func;
      cnt_e = '0;
      unique case (op_t'(in_ch.func))
        OP_RESET: begin
          phase_eff = PH_RST_LOW;
        end
        OP_WBYTE: begin
          phase_eff = PH_WR_LOW;
          sb_e      = in_ch.data_value;
        end
        OP_WBIT: begin
          phase_eff = PH_WR_LOW;
          sb_e      = {{(DATA_W-1){1'b0}}, in_ch.data_value[0]};
        end
        default: begin
          phase_eff = PH_RD_LOW;
          sb_e      = '0;
        end
      endcase
    end
  end

  // Next state, with the completion status that goes with it
  always_comb begin
    phase_nxt = phase_eff;
    op_nxt    = op_e;
    sb_nxt    = sb_e;
    bidx_nxt  = start ? '0 : bidx_r;
    cnt_inc   = cnt_e + CW'(1);
    cnt_nxt   = cnt_e[CNT_W-1:0];
    lim       = '0;
    done      = 1'b0;
    err       = 1'b0;
    rv        = '0;
    unique case (phase_eff)
      PH_RST_LOW: begin
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= {1'b0, reset_low_r}) begin
          phase_nxt = PH_RST_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_RST_HIGH: begin
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= RECOVER_LIM) begin
          phase_nxt = PH_PRES_WAIT;
          cnt_nxt   = '0;
        end
      end
      PH_PRES_WAIT: begin
        lim = CW'(pres_wait_r);
        if (cnt_e >= lim) begin
          err  = 1'b1;
          done = 1'b1;
        end else if (in_ch.line_level) begin
          cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= lim) begin
            err  = 1'b1;
            done = 1'b1;
          end
        end else if (pres_low_r <= LIM_W'(1)) begin
          err  = 1'b1;
          done = 1'b1;
        end else begin
          cnt_nxt   = CNT_W'(1);
          phase_nxt = PH_PRES_LOW;
        end
      end
      PH_PRES_LOW: begin
        lim = CW'(pres_low_r);
        if (cnt_e >= lim) begin
          err  = 1'b1;
          done = 1'b1;
        end else if (!in_ch.line_level) begin
          cnt_nxt = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= lim) begin
            err  = 1'b1;
            done = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
      PH_WR_LOW: begin
        lim     = sb_e[0] ? CW'(wr_one_low_r) : CW'(wr_zero_low_r);
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= lim) begin
          phase_nxt = PH_WR_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_WR_HIGH: begin
        lim     = sb_e[0] ? WR1_HI_LIM : WR0_HI_LIM;
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= lim) begin
          cnt_nxt = '0;
          sb_nxt  = sb_e >> 1;
          if (op_e == OP_WBIT || bidx_nxt == '1) begin
            done = 1'b1;
          end else begin
            bidx_nxt  = bidx_nxt + BIDX_W'(1);
            phase_nxt = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= CW'(rd_low_r)) begin
          phase_nxt = PH_RD_TAIL;
          cnt_nxt   = '0;
        end
      end
      PH_RD_TAIL: begin
        // The bit is sampled on the first released tick of the slot.
        if (cnt_e == '0) begin
          if (op_e == OP_RBIT) begin
            sb_nxt = {{(DATA_W-1){1'b0}}, in_ch.line_level};
          end else begin
            sb_nxt = {in_ch.line_level, sb_e[DATA_W-1:1]};
          end
        end
        cnt_nxt = cnt_inc[CNT_W-1:0];
        if (cnt_inc >= TAIL_LIM) begin
          cnt_nxt = '0;
          if (op_e == OP_RBIT || bidx_nxt == '1) begin
            rv   = sb_nxt;
            done = 1'b1;
          end else begin
            bidx_nxt  = bidx_nxt + BIDX_W'(1);
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    if (done) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      bidx_nxt  = '0;
    end
  end

  // Line drive for this tick
  always_comb begin
    lo = 1'b0;
    hi = 1'b0;
    unique case (phase_eff) inside
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: lo = 1'b1;
      PH_RST_HIGH, PH_WR_HIGH:          hi = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    sel = '0;
    if (bus_select_r < SEL_W'(LINES)) begin
      sel[bus_select_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      op_r        <= '0;
      cnt_r       <= '0;
      bidx_r      <= '0;
      sb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        op_r    <= op_nxt;
        cnt_r   <= cnt_nxt;
        bidx_r  <= bidx_nxt;
        sb_r    <= sb_nxt;
      end
      if (in_ch.ready) begin
        out_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lo_mask_r <= lo ? sel : '0;
      hi_mask_r <= hi ? sel : '0;
      busy_r    <= (phase_nxt != PH_IDLE);
      done_r    <= done;
      err_r     <= err;
      rv_r      <= rv;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_low_mask  = lo_mask_r;
  assign out_ch.drive_high_mask = hi_mask_r;
  assign out_ch.busy_res        = busy_r;
  assign out_ch.done_res        = done_r;
  assign out_ch.presence_error  = err_r;
  assign out_ch.read_value      = rv_r;

endmodule

// ===== tb/tb_one_wire_master.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_wire_master: self-checking testbench of the one-wire bus master
// A queued driver feeds bus ticks in bursts. A clocked monitor predicts every
// tick's result and compares it with what the block returns, while the
// receiver stalls on a changing pattern. Phases with different timing
// settings cover reset/presence, byte and bit slots, and the corner cases.
// ----------------------------------------------------------------------------
module tb_one_wire_master;
  import owm_pkg::*;

  localparam int RECOVER_TICKS = 15;
  localparam int WR1_HIGH      = 58;
  localparam int WR0_HIGH      = 2;
  localparam int RD_TAIL_TICKS = 45;
  localparam int WATCHDOG      = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [1:0] BUS_NONE = 2'd3;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] data;
    logic              line;
  } tick_item_t;

  typedef struct packed {
    logic [LINES-1:0]  drive_low;
    logic [LINES-1:0]  drive_high;
    logic              busy;
    logic              done;
    logic              perr;
    logic [DATA_W-1:0] rdval;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDATA_W-1:0] cfg_wdata = '0;

  owm_in_if  in_ch();
  owm_out_if out_ch();

  one_wire_master #(
    .RESET_RECOVER_TICKS  (RECOVER_TICKS),
    .WRITE_ONE_HIGH_TICKS (WR1_HIGH),
    .WRITE_ZERO_HIGH_TICKS(WR0_HIGH),
    .READ_TAIL_TICKS      (RD_TAIL_TICKS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_item_t   pending_ticks[$];
  tick_result_t expected_results[$];
  int items_pushed = 0;
  int results_seen = 0;
  int err_count = 0;
  logic in_fire = 1'b0;

  // Timing registers as the block holds them, and the bus state machine.
  logic [1:0] m_bus;
  int m_rst_low, m_pres_wait, m_pres_low, m_wr1_low, m_wr0_low, m_rd_low;
  phase_t bus_phase;
  logic [FUNC_W-1:0] bus_op;
  int slot_cnt, bit_pos;
  logic [DATA_W-1:0] shreg;

  function automatic logic end_op();
    bus_phase = PH_IDLE;
    slot_cnt = 0;
    bit_pos = 0;
    return 1'b1;
  endfunction

  function automatic tick_result_t bus_tick(input tick_item_t it);
    tick_result_t r;
    logic pull_low, push_high;
    logic [LINES-1:0] sel;
    int lim;
    r = '0;
    pull_low = 1'b0;
    push_high = 1'b0;
    if (bus_phase == PH_IDLE && it.func >= OP_RESET && it.func <= OP_RBIT) begin
      bus_op = it.func;
      slot_cnt = 0;
      bit_pos = 0;
      case (it.func)
        OP_RESET: bus_phase = PH_RST_LOW;
        OP_WBYTE: begin
          shreg = it.data;
          bus_phase = PH_WR_LOW;
        end
        OP_WBIT: begin
          shreg = {7'd0, it.data[0]};
          bus_phase = PH_WR_LOW;
        end
        default: begin
          shreg = '0;
          bus_phase = PH_RD_LOW;
        end
      endcase
    end
    case (bus_phase)
      PH_RST_LOW: begin
        pull_low = 1'b1;
        slot_cnt++;
        if (slot_cnt >= m_rst_low) begin
          bus_phase = PH_RST_HIGH;
          slot_cnt = 0;
        end
      end
      PH_RST_HIGH: begin
        push_high = 1'b1;
        slot_cnt++;
        if (slot_cnt >= RECOVER_TICKS) begin
          bus_phase = PH_PRES_WAIT;
          slot_cnt = 0;
        end
      end
      PH_PRES_WAIT: begin
        if (slot_cnt >= m_pres_wait) begin
          r.perr = 1'b1;
        end else if (it.line) begin
          slot_cnt++;
          if (slot_cnt >= m_pres_wait) r.perr = 1'b1;
        end else if (m_pres_low <= 1) begin
          r.perr = 1'b1;
        end else begin
          // The first low tick already counts toward the presence pulse.
          slot_cnt = 1;
          bus_phase = PH_PRES_LOW;
        end
        if (r.perr) r.done = end_op();
      end
      PH_PRES_LOW: begin
        if (slot_cnt >= m_pres_low) begin
          r.perr = 1'b1;
          r.done = end_op();
        end else if (!it.line) begin
          slot_cnt++;
          if (slot_cnt >= m_pres_low) begin
            r.perr = 1'b1;
            r.done = end_op();
          end
        end else begin
          r.done = end_op();
        end
      end
      PH_WR_LOW: begin
        pull_low = 1'b1;
        slot_cnt++;
        lim = shreg[0] ? m_wr1_low : m_wr0_low;
        if (slot_cnt >= lim) begin
          bus_phase = PH_WR_HIGH;
          slot_cnt = 0;
        end
      end
      PH_WR_HIGH: begin
        push_high = 1'b1;
        slot_cnt++;
        lim = shreg[0] ? WR1_HIGH : WR0_HIGH;
        if (slot_cnt >= lim) begin
          slot_cnt = 0;
          shreg = shreg >> 1;
          if (bus_op == OP_WBIT || bit_pos >= 7) begin
            r.done = end_op();
          end else begin
            bit_pos++;
            bus_phase = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        pull_low = 1'b1;
        slot_cnt++;
        if (slot_cnt >= m_rd_low) begin
          bus_phase = PH_RD_TAIL;
          slot_cnt = 0;
        end
      end
      PH_RD_TAIL: begin
        // The bit is sampled on the first released tick of the slot.
        if (slot_cnt == 0) begin
          if (bus_op == OP_RBIT) shreg = {7'd0, it.line};
          else shreg = {it.line, shreg[7:1]};
        end
        slot_cnt++;
        if (slot_cnt >= RD_TAIL_TICKS) begin
          slot_cnt = 0;
          if (bus_op == OP_RBIT || bit_pos >= 7) begin
            r.rdval = shreg;
            r.done = end_op();
          end else begin
            bit_pos++;
            bus_phase = PH_RD_LOW;
          end
        end
      end
      default: bus_phase = PH_IDLE;
    endcase
    sel = (m_bus != BUS_NONE) ? (3'b001 << m_bus) : 3'b000;
    r.drive_low = pull_low ? sel : 3'b000;
    r.drive_high = push_high ? sel : 3'b000;
    r.busy = (bus_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Input acceptance feeds the predictor; result acceptance is checked.
  tick_item_t   mon_item;
  tick_result_t mon_exp;
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        mon_item.func = in_ch.func;
        mon_item.data = in_ch.data_value;
        mon_item.line = in_ch.line_level;
        expected_results.push_back(bus_tick(mon_item));
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          err_count++;
          $display("%0t: result with no item waiting: expected none, actual %0h",
                   $time, {out_ch.drive_low_mask, out_ch.drive_high_mask,
                   out_ch.busy_res, out_ch.done_res, out_ch.presence_error,
                   out_ch.read_value});
        end else begin
          mon_exp = expected_results.pop_front();
          check_field("drive_low_mask", mon_exp.drive_low, out_ch.drive_low_mask);
          check_field("drive_high_mask", mon_exp.drive_high, out_ch.drive_high_mask);
          check_field("busy_res", mon_exp.busy, out_ch.busy_res);
          check_field("done_res", mon_exp.done, out_ch.done_res);
          check_field("presence_error", mon_exp.perr, out_ch.presence_error);
          check_field("read_value", mon_exp.rdval, out_ch.read_value);
        end
      end
    end
  end

  // Sender: bursts of items separated by random gaps.
  tick_item_t drv_item;
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left > 0 || pending_ticks.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        drv_item = pending_ticks.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.func       <= drv_item.func;
        in_ch.data_value <= drv_item.data;
        in_ch.line_level <= drv_item.line;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random, and a long hold-off is
  // taken when more than 20 items wait to be sent and none was taken recently.
  // The first hold-off comes early, while the opening items are still queued.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  int rx_since_hold = 1450;
  int rx_cyc = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cyc++;
      rx_since_hold++;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (pending_ticks.size() > 20 && rx_since_hold > 1500) begin
        rx_hold_left = HOLD_CYCLES;
        rx_since_hold = 0;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 1) == 1);
          default: out_ch.ready <= ((rx_cyc % 4) != 0);
        endcase
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(input cfg_idx_t idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CDATA_W-1:0];
    case (idx)
      CFG_BUS_SELECT:  m_bus = value[1:0];
      CFG_RESET_LOW:   m_rst_low = value & 1023;
      CFG_PRES_WAIT:   m_pres_wait = value & 255;
      CFG_PRES_LOW:    m_pres_low = value & 255;
      CFG_WR_ONE_LOW:  m_wr1_low = value & 255;
      CFG_WR_ZERO_LOW: m_wr0_low = value & 255;
      default:         m_rd_low = value & 255;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input int bus, input int rst_low, input int pw, input int pl,
                              input int w1, input int w0, input int rd);
    cfg_write(CFG_BUS_SELECT, bus);
    cfg_write(CFG_RESET_LOW, rst_low);
    cfg_write(CFG_PRES_WAIT, pw);
    cfg_write(CFG_PRES_LOW, pl);
    cfg_write(CFG_WR_ONE_LOW, w1);
    cfg_write(CFG_WR_ZERO_LOW, w0);
    cfg_write(CFG_RD_LOW, rd);
  endtask

  task automatic wait_drained();
    wait (results_seen == items_pushed);
    repeat (3) @(negedge clk);
  endtask

  task automatic push_item(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] d,
                           input logic ln);
    tick_item_t it;
    it.func = f;
    it.data = d;
    it.line = ln;
    pending_ticks.push_back(it);
    items_pushed++;
  endtask

  task automatic push_ticks(input int n, input logic ln);
    repeat (n) push_item(OP_TICK, DATA_W'($urandom), ln);
  endtask

  // Issues one command and enough ticks to carry it to the end. For a reset
  // the line is high for wait_hi ticks after recovery, then low for low_len.
  // A noisy operation gets stray commands while busy and may be cut short.
  task automatic gen_op(input logic [FUNC_W-1:0] cmd, input logic [DATA_W-1:0] d,
                        input int wait_hi, input int low_len, input bit noisy);
    int n, k, pre, b;
    logic [FUNC_W-1:0] f;
    logic ln;
    pre = ((m_rst_low > 0) ? m_rst_low : 1) + RECOVER_TICKS;
    n = 0;
    case (cmd)
      OP_RESET: n = pre + wait_hi + low_len + 1;
      OP_WBYTE, OP_WBIT: begin
        for (b = 0; b < ((cmd == OP_WBIT) ? 1 : 8); b++) begin
          if (d[b]) n += ((m_wr1_low > 0) ? m_wr1_low : 1) + WR1_HIGH;
          else n += ((m_wr0_low > 0) ? m_wr0_low : 1) + WR0_HIGH;
        end
      end
      default: n = (((m_rd_low > 0) ? m_rd_low : 1) + RD_TAIL_TICKS) *
                   ((cmd == OP_RBYTE) ? 8 : 1);
    endcase
    if (noisy && $urandom_range(0, 3) == 0) n = $urandom_range(1, n);
    for (k = 0; k < n; k++) begin
      f = (k == 0) ? cmd : OP_TICK;
      if (k > 0 && noisy && (k == 1 || $urandom_range(0, 7) == 0))
        f = FUNC_W'($urandom_range(1, 7));
      if (cmd == OP_RESET && k >= pre)
        ln = !(k >= pre + wait_hi && k < pre + wait_hi + low_len);
      else
        ln = 1'($urandom_range(0, 1));
      push_item(f, (k == 0) ? d : DATA_W'($urandom), ln);
    end
    repeat ($urandom_range(0, 3)) begin
      f = (noisy && $urandom_range(0, 1))
          ? FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI)) : OP_TICK;
      push_item(f, DATA_W'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic gen_random_op();
    int pick, wait_hi, low_len;
    bit noisy;
    pick = $urandom_range(0, 99);
    noisy = ($urandom_range(0, 9) == 0);
    if (pick < 35) begin
      if (m_pres_wait > 0 && $urandom_range(0, 3) != 0)
        wait_hi = $urandom_range(0, m_pres_wait - 1);
      else
        wait_hi = $urandom_range(m_pres_wait, m_pres_wait + 2);
      if (m_pres_low > 1 && $urandom_range(0, 3) != 0)
        low_len = $urandom_range(1, m_pres_low - 1);
      else
        low_len = $urandom_range(0, m_pres_low + 2);
      gen_op(OP_RESET, DATA_W'($urandom), wait_hi, low_len, noisy);
    end else if (pick < 60) begin
      gen_op(OP_WBIT, DATA_W'($urandom), 0, 0, noisy);
    end else if (pick < 85) begin
      gen_op(OP_RBIT, DATA_W'($urandom), 0, 0, noisy);
    end else begin
      gen_op(OP_WBYTE, DATA_W'($urandom), 0, 0, noisy);
    end
  endtask

  int phase_start;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = OP_TICK;
    in_ch.data_value = '0;
    in_ch.line_level = 1'b0;
    out_ch.ready = 1'b0;
    m_bus = BUS_SELECT_RST;
    m_rst_low = RESET_LOW_RST;
    m_pres_wait = PRES_WAIT_RST;
    m_pres_low = PRES_LOW_RST;
    m_wr1_low = WR_ONE_LOW_RST;
    m_wr0_low = WR_ZERO_LOW_RST;
    m_rd_low = RD_LOW_RST;
    bus_phase = PH_IDLE;
    bus_op = OP_TICK;
    slot_cnt = 0;
    bit_pos = 0;
    shreg = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values of the timing registers.
    gen_op(OP_WBIT, 8'h01, 0, 0, 1'b0);
    gen_op(OP_RBIT, 8'h00, 0, 0, 1'b0);
    wait_drained();

    // Short timings: good presence, missing presence, stuck presence, and
    // byte and bit writes; also commands while busy and unknown codes.
    apply_config(1, 3, 4, 5, 2, 3, 2);
    gen_op(OP_RESET, 8'h00, 2, 3, 1'b0);
    gen_op(OP_RESET, 8'h00, 6, 0, 1'b0);
    gen_op(OP_RESET, 8'h00, 1, 7, 1'b0);
    gen_op(OP_RESET, 8'h00, 3, 4, 1'b0);
    gen_op(OP_WBYTE, 8'h10, 0, 0, 1'b1);
    gen_op(OP_WBIT, 8'hFE, 0, 0, 1'b0);
    push_item(FUNC_UNUSED_LO, 8'hFF, 1'b1);
    push_item(FUNC_UNUSED_HI, 8'h00, 1'b0);
    wait_drained();

    // No line selected and every time register at zero.
    apply_config(BUS_NONE, 0, 0, 0, 0, 0, 0);
    gen_op(OP_RESET, 8'h00, 0, 0, 1'b0);
    gen_op(OP_RBYTE, 8'h00, 0, 0, 1'b0);
    gen_op(OP_WBIT, 8'h01, 0, 0, 1'b0);
    wait_drained();

    // A presence low limit of one fails on the first low tick.
    apply_config(2, 2, 3, 1, 1, 1, 1);
    gen_op(OP_RESET, 8'h00, 1, 1, 1'b0);
    wait_drained();

    // The reset low time is shortened while the pulse is already longer.
    apply_config(0, 40, 10, 10, 20, 20, 20);
    push_item(OP_RESET, 8'h00, 1'b1);
    push_ticks(19, 1'b1);
    wait_drained();
    cfg_write(CFG_RESET_LOW, 5);
    push_ticks(RECOVER_TICKS + 3, 1'b1);
    push_ticks(3, 1'b0);
    push_ticks(2, 1'b1);
    wait_drained();

    // Largest presence limits and slot times.
    apply_config(2, 1, 255, 255, 255, 255, 255);
    gen_op(OP_RESET, 8'h00, 3, 2, 1'b0);
    wait_drained();

    // Random operations under random short timings.
    apply_config(($urandom_range(0, 9) == 0) ? BUS_NONE : $urandom_range(0, 2),
                 $urandom_range(0, 30), $urandom_range(0, 25), $urandom_range(0, 25),
                 $urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8));
    phase_start = items_pushed;
    while (items_pushed - phase_start < 60) gen_random_op();
    wait_drained();

    repeat (10) @(negedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
